[hw/rtl/rtsd_pkg.sv]
// Shared types, constants and helper functions for the range to segment display block.
`timescale 1ns / 1ps

package rtsd_pkg;

    localparam int DIGIT_COUNT = 5;
    localparam int WORD_LEN    = 5;
    localparam int POS_W       = $clog2(DIGIT_COUNT + 1);

    // floor(x / 100) is taken as floor(floor(x / 4) / 25) with a reciprocal of 25.
    localparam logic [24:0] DIST_RECIP  = 25'd21474837;
    localparam int          DIST_SHIFT  = 29;
    localparam logic [13:0] SHINE_RECIP = 14'd10486;
    localparam int          SHINE_SHIFT = 18;

    typedef enum logic [1:0] {
        REG_SCALE = 2'd0,
        REG_NEAR  = 2'd1,
        REG_FAR   = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        CLS_DIGITS = 2'd0,
        CLS_CLOSE  = 2'd1,
        CLS_FAR    = 2'd2
    } range_class_t;

    typedef struct packed {
        logic [9:0] scale_numerator;
        logic [6:0] near_limit;
        logic [6:0] far_limit;
    } cfg_t;

    typedef struct packed {
        logic [6:0]   distance;
        range_class_t cls;
        logic [7:0]   duty_first;
        logic [7:0]   duty_second;
        logic [7:0]   duty_third;
        logic [3:0]   hund;
        logic [3:0]   tens;
        logic [3:0]   units;
    } disp_t;

    function automatic logic [6:0] digit_seg(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] close_letter(input logic [2:0] j);
        logic [6:0] s;
        case (j)
            3'd0:    s = 7'h39;
            3'd1:    s = 7'h38;
            3'd2:    s = 7'h3F;
            3'd3:    s = 7'h6D;
            3'd4:    s = 7'h79;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] far_letter(input logic [2:0] j);
        logic [6:0] s;
        case (j)
            3'd2:    s = 7'h71;
            3'd3:    s = 7'h77;
            3'd4:    s = 7'h31;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // Splits a value below 128 into hundreds, tens and units.
    function automatic logic [11:0] split_digits(input logic [6:0] d);
        logic [6:0]  r;
        logic [3:0]  h;
        logic [3:0]  t;
        logic [14:0] p;
        logic [6:0]  t10;
        h = (d >= 7'd100) ? 4'd1 : 4'd0;
        r = (d >= 7'd100) ? (d - 7'd100) : d;
        p = {8'b0, r} * 15'd205;
        t = p[14:11];
        t10 = {t[3:0], 3'b0} - 7'd0 + {2'b0, t[3:0], 1'b0};
        return {h, t, 4'(r - t10)};
    endfunction

    function automatic logic [6:0] pos_segments(input logic [POS_W-1:0] pos, input disp_t it);
        int         j;
        int         e;
        logic [6:0] s;
        j = int'(pos) + WORD_LEN - DIGIT_COUNT - 1;
        e = DIGIT_COUNT - int'(pos);
        s = 7'h00;
        case (it.cls)
            CLS_CLOSE:
            begin
                if (j >= 0 && j < WORD_LEN)
                begin
                    s = close_letter(3'(j));
                end
            end
            CLS_FAR:
            begin
                if (j >= 0 && j < WORD_LEN)
                begin
                    s = far_letter(3'(j));
                end
            end
            CLS_DIGITS:
            begin
                if (e == 0)
                begin
                    s = digit_seg(it.units);
                end
                else if (e == 1 && it.distance >= 7'd10)
                begin
                    s = digit_seg(it.tens);
                end
                else if (e == 2 && it.distance >= 7'd100)
                begin
                    s = digit_seg(it.hund);
                end
            end
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/rtsd_cfg.sv]
// APB register file holding the scale factor and the two distance limits.
`timescale 1ns / 1ps

module rtsd_cfg
    import rtsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_numerator <= 10'd157;
            cfg_reg.near_limit      <= 7'd10;
            cfg_reg.far_limit       <= 7'd100;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_SCALE: cfg_reg.scale_numerator <= pwdata[9:0];
                REG_NEAR:  cfg_reg.near_limit      <= pwdata[6:0];
                REG_FAR:   cfg_reg.far_limit       <= pwdata[6:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SCALE: prdata = {22'b0, cfg_reg.scale_numerator};
            REG_NEAR:  prdata = {25'b0, cfg_reg.near_limit};
            REG_FAR:   prdata = {25'b0, cfg_reg.far_limit};
            default:   prdata = 32'b0;
        endcase
    end

endmodule

[hw/rtl/rtsd_pipe.sv]
// Four stage pipeline from echo ticks to distance class, duties and decimal digits.
`timescale 1ns / 1ps

module rtsd_pipe
    import rtsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic [15:0] echo_ticks,
    input  logic        en,
    output logic        out_valid,
    output disp_t       out_item
);

    logic         v1_reg;
    logic         v2_reg;
    logic         v3_reg;
    logic         v4_reg;
    logic [25:0]  prod1_reg;
    logic [48:0]  prod2_reg;
    logic [6:0]   dist3_reg;
    range_class_t cls3_reg;
    logic [14:0]  bright3_reg;
    disp_t        item4_reg;

    logic [19:0]  dist_full;
    range_class_t cls_next;
    logic [14:0]  bright_next;
    logic [26:0]  shine_prod;
    logic [8:0]   shine_raw;
    logic [7:0]   shine;
    logic [11:0]  digits;
    disp_t        item4_next;

    assign out_valid = v4_reg;
    assign out_item  = item4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        dist_full = prod2_reg[DIST_SHIFT +: 20];
        if (dist_full <= {13'b0, cfg.near_limit})
        begin
            cls_next = CLS_CLOSE;
        end
        else if (dist_full >= {13'b0, cfg.far_limit})
        begin
            cls_next = CLS_FAR;
        end
        else
        begin
            cls_next = CLS_DIGITS;
        end
        bright_next = {dist_full[6:0], 8'b0} - {8'b0, dist_full[6:0]};
    end

    always_comb
    begin
        shine_prod = {14'b0, bright3_reg[14:2]} * {13'b0, SHINE_RECIP};
        shine_raw  = shine_prod[SHINE_SHIFT +: 9];
        shine      = shine_raw[8] ? 8'hFF : shine_raw[7:0];
        digits     = split_digits(dist3_reg);

        item4_next.distance = dist3_reg;
        item4_next.cls      = cls3_reg;
        item4_next.hund     = digits[11:8];
        item4_next.tens     = digits[7:4];
        item4_next.units    = digits[3:0];
        case (cls3_reg)
            CLS_CLOSE:
            begin
                item4_next.duty_first  = 8'hFF;
                item4_next.duty_second = 8'hFF;
                item4_next.duty_third  = 8'hFF;
            end
            CLS_FAR:
            begin
                item4_next.duty_first  = 8'hFF;
                item4_next.duty_second = 8'h00;
                item4_next.duty_third  = 8'h00;
            end
            default:
            begin
                item4_next.duty_first  = shine;
                item4_next.duty_second = 8'hFF - shine;
                item4_next.duty_third  = 8'hFF - shine;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg   <= {10'b0, echo_ticks} * {16'b0, cfg.scale_numerator};
            prod2_reg   <= {25'b0, prod1_reg[25:2]} * {24'b0, DIST_RECIP};
            dist3_reg   <= dist_full[6:0];
            cls3_reg    <= cls_next;
            bright3_reg <= bright_next;
            item4_reg   <= item4_next;
        end
    end

endmodule

[hw/rtl/rtsd_ser.sv]
// Output stage that holds one measurement and sends one request per display position.
`timescale 1ns / 1ps

module rtsd_ser
    import rtsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  disp_t       in_item,
    output logic        in_take,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    disp_t            item_reg;
    logic [POS_W-1:0] pos_reg;
    logic             ovalid_reg;
    logic             last_beat;
    logic             slot_free;

    assign last_beat = (pos_reg == POS_W'(DIGIT_COUNT));
    assign slot_free = !ovalid_reg || (m_tready && last_beat);
    assign in_take   = in_valid && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            pos_reg    <= POS_W'(1);
        end
        else if (in_take)
        begin
            ovalid_reg <= 1'b1;
            pos_reg    <= POS_W'(1);
        end
        else if (ovalid_reg && m_tready)
        begin
            if (last_beat)
            begin
                ovalid_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = last_beat;
    assign m_tuser  = item_reg.cls;
    assign m_tdata  = {6'b0, item_reg.duty_third, item_reg.duty_second, item_reg.duty_first,
                       pos_segments(pos_reg, item_reg), 3'(pos_reg)};

endmodule

[hw/rtl/range_to_segment_display_top.sv]
// Top level of the range to segment display block.
`timescale 1ns / 1ps

// Channel  Direction  Content
// s_       in         one echo pulse width per request
// m_       out        one display position per request, five per measurement
// APB      in         scale factor, near limit, far limit
//
// A measurement passes four register stages (product, reciprocal product,
// classification, duties and digits) and is then registered in the output
// stage, which offers its first position and sends one position per cycle
// while m_tready is high. A stall on the output holds the whole pipeline
// once its last stage holds a measurement; nothing is lost or repeated.
// Reset clears all valid bits and sets the registers to 157, 10 and 100.

module range_to_segment_display_top
    import rtsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // echo_ticks
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digit_position, segments, duty_first, duty_second, duty_third
    output logic [1:0]  m_tuser,   // range_class
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg;
    logic  pipe_valid;
    disp_t pipe_item;
    logic  ser_take;
    logic  en;

    assign en       = !pipe_valid || ser_take;
    assign s_tready = en;

    rtsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rtsd_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .echo_ticks (s_tdata),
        .en         (en),
        .out_valid  (pipe_valid),
        .out_item   (pipe_item)
    );

    rtsd_ser u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pipe_valid),
        .in_item  (pipe_item),
        .in_take  (ser_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
